>>> hdl/gdds_pkg.sv
package gdds_pkg;

   // Grid geometry and limits.
   localparam int GridRows       = 64;
   localparam int GridCols       = 64;
   localparam int CellSizePixels = 10;
   localparam int HomeLimit      = 15;

   localparam int RadiusPx  = 100;
   localparam int RadiusSq  = 10000;
   localparam int Cells     = GridRows * GridCols;
   localparam int AddrW     = (Cells > 1) ? $clog2(Cells) : 1;
   localparam int HomeW     = $clog2(HomeLimit + 1);

   // Item modes.
   localparam logic ModeWrite = 1'b0;
   localparam logic ModeQuery = 1'b1;

   // Window reach in cells and the squared-offset range that lies inside the disk.
   localparam int Reach      = RadiusPx / CellSizePixels;
   localparam int CellSq     = CellSizePixels * CellSizePixels;
   localparam int MaxS       = RadiusSq / CellSq;
   localparam int TableDepth = MaxS + 1;
   localparam int TblIdxW    = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int OffW       = $clog2(Reach + 1) + 1;
   localparam int SqW        = $clog2(2 * Reach * Reach + MaxS + 1);
   localparam int PosW       = 10;

   localparam logic signed [OffW-1:0] OffMin = OffW'(-Reach);
   localparam logic signed [OffW-1:0] OffMax = OffW'(Reach);

   // Weight and accumulator widths.
   localparam int WeightW  = 17;
   localparam int ProdW    = HomeW + WeightW;
   localparam int AccW     = 40;
   localparam int DensityW = 30;
   localparam logic [AccW-1:0] DensityMax = AccW'(1073741823);

   // Series evaluation of exp(-x) in Q16.48.
   localparam int ExpTerms = 40;
   localparam logic [63:0] ExpOne = 64'd1 << 48;
   localparam logic [63:0] ExpDivisor [1:ExpTerms] = '{
      64'd10000,  64'd20000,  64'd30000,  64'd40000,  64'd50000,
      64'd60000,  64'd70000,  64'd80000,  64'd90000,  64'd100000,
      64'd110000, 64'd120000, 64'd130000, 64'd140000, 64'd150000,
      64'd160000, 64'd170000, 64'd180000, 64'd190000, 64'd200000,
      64'd210000, 64'd220000, 64'd230000, 64'd240000, 64'd250000,
      64'd260000, 64'd270000, 64'd280000, 64'd290000, 64'd300000,
      64'd310000, 64'd320000, 64'd330000, 64'd340000, 64'd350000,
      64'd360000, 64'd370000, 64'd380000, 64'd390000, 64'd400000
   };

   typedef logic [WeightW-1:0] weight_type;
   typedef weight_type weight_table_type [TableDepth];

   // Input word and result word.
   typedef struct packed {
      logic       mode;
      logic [5:0] row;
      logic [5:0] col;
      logic [3:0] homes;
      logic       open_cell;
   } req_type;

   typedef struct packed {
      logic [DensityW-1:0] density;
      logic                computed;
   } rsp_type;

   // One stored cell and the write port of the cell memory.
   typedef struct packed {
      logic             open_mark;
      logic [HomeW-1:0] homes;
   } cell_type;

   typedef struct packed {
      logic             en;
      logic [AddrW-1:0] addr;
      cell_type         data;
   } ram_wr_type;

   // Weight for each squared cell offset: exp(-s*CellSq/10000) rounded to Q1.16.
   function automatic weight_table_type build_weights();
      weight_table_type tbl;
      logic [63:0]      term;
      logic [63:0]      even_sum;
      logic [63:0]      odd_sum;
      logic [63:0]      val;
      logic [63:0]      n;
      for (int s = 0; s < TableDepth; s++) begin
         n        = 64'(s * CellSq);
         term     = ExpOne;
         even_sum = ExpOne;
         odd_sum  = 64'd0;
         for (int k = 1; k <= ExpTerms; k++) begin
            term = (term * n) / ExpDivisor[k];
            if ((k % 2) == 1) begin
               odd_sum = odd_sum + term;
            end else begin
               even_sum = even_sum + term;
            end
         end
         val    = (even_sum >= odd_sum) ? (even_sum - odd_sum) : 64'd0;
         val    = (val + (64'd1 << 31)) >> 32;
         tbl[s] = val[WeightW-1:0];
      end
      return tbl;
   endfunction

   localparam weight_table_type WeightTable = build_weights();

   // Linear cell address of an on-grid row and column.
   function automatic logic [AddrW-1:0] cell_addr(input logic [7:0] row, input logic [7:0] col);
      return AddrW'(32'(row) * GridCols + 32'(col));
   endfunction

endpackage

>>> hdl/gdds_cell_ram.sv
module gdds_cell_ram (
   input  logic                        clock,
   input  gdds_pkg::ram_wr_type        wr,
   input  logic [gdds_pkg::AddrW-1:0]  rd_addr,
   output gdds_pkg::cell_type          rd_data
);

   gdds_pkg::cell_type mem_ff [gdds_pkg::Cells];
   gdds_pkg::cell_type rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/gaussian_disk_density_sum.sv
// Write word: taken with no result; busy stays low.
// Query word for an open cell: a center read, a sweep of the 21 by 21 window (one cell memory
// read per cycle), a drain of the multiply-accumulate pipeline, a saturation of the sum, then
// the result strobe. Service or off-grid cells answer without a sweep, as not computed. A new
// word can be taken in the strobe cycle; results cannot be stalled.
// Synchronous reset starts a clearing pass over all 4096 cells of the cell memory; busy is high.
module gaussian_disk_density_sum (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gdds_pkg::req_type req_word,
   output logic              rsp_strobe,
   output gdds_pkg::rsp_type rsp_word
);

   typedef enum logic [5:0] {
      StClear  = 6'b000001,
      StIdle   = 6'b000010,
      StCheck  = 6'b000100,
      StSweep  = 6'b001000,
      StDrain  = 6'b010000,
      StFinish = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [gdds_pkg::AddrW-1:0]        clr_addr_ff, clr_addr_in;
   logic [5:0]                        q_row_ff, q_row_in;
   logic [5:0]                        q_col_ff, q_col_in;
   logic signed [gdds_pkg::OffW-1:0]  dr_ff, dr_in;
   logic signed [gdds_pkg::OffW-1:0]  dc_ff, dc_in;
   logic                              drain_ff, drain_in;
   logic                              tap_ff, tap_in;
   gdds_pkg::weight_type              weight_ff, weight_in;
   logic [gdds_pkg::ProdW-1:0]        prod_ff, prod_in;
   logic [gdds_pkg::AccW-1:0]         acc_ff, acc_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   gdds_pkg::rsp_type                 rsp_word_ff, rsp_word_in;

   logic                              accept;
   logic                              req_on_grid;
   logic [7:0]                        homes_ext;
   logic [7:0]                        homes_sat;
   gdds_pkg::ram_wr_type              ram_wr;
   logic [gdds_pkg::AddrW-1:0]        ram_rd_addr;
   gdds_pkg::cell_type                ram_rd_data;

   logic signed [gdds_pkg::PosW-1:0]    r_pos;
   logic signed [gdds_pkg::PosW-1:0]    c_pos;
   logic                                tap_on_grid;
   logic signed [2*gdds_pkg::OffW-1:0]  dr_ext;
   logic signed [2*gdds_pkg::OffW-1:0]  dc_ext;
   logic signed [2*gdds_pkg::OffW-1:0]  dr_sq;
   logic signed [2*gdds_pkg::OffW-1:0]  dc_sq;
   logic [gdds_pkg::SqW-1:0]            off_sq;
   logic                                in_radius;
   logic [gdds_pkg::TblIdxW-1:0]        tbl_idx;
   logic [gdds_pkg::AddrW-1:0]          sweep_addr;
   logic                                sweep_last;

   gdds_cell_ram u_cell_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept = start && !busy;
   assign busy   = (state_ff != StIdle);

   // Decode of the incoming word.
   always_comb begin
      req_on_grid = (32'(req_word.row) < gdds_pkg::GridRows) &&
                    (32'(req_word.col) < gdds_pkg::GridCols);
      homes_ext   = 8'(req_word.homes);
      homes_sat   = (homes_ext > 8'(gdds_pkg::HomeLimit)) ? 8'(gdds_pkg::HomeLimit) : homes_ext;
   end

   // Window position of the current sweep step.
   always_comb begin
      r_pos       = $signed(gdds_pkg::PosW'(q_row_ff)) + gdds_pkg::PosW'(dr_ff);
      c_pos       = $signed(gdds_pkg::PosW'(q_col_ff)) + gdds_pkg::PosW'(dc_ff);
      tap_on_grid = (r_pos >= 0) && (r_pos < gdds_pkg::GridRows) &&
                    (c_pos >= 0) && (c_pos < gdds_pkg::GridCols);
      dr_ext      = (2*gdds_pkg::OffW)'(dr_ff);
      dc_ext      = (2*gdds_pkg::OffW)'(dc_ff);
      dr_sq       = dr_ext * dr_ext;
      dc_sq       = dc_ext * dc_ext;
      off_sq      = gdds_pkg::SqW'($unsigned(dr_sq)) + gdds_pkg::SqW'($unsigned(dc_sq));
      in_radius   = (32'(off_sq) <= gdds_pkg::MaxS);
      tbl_idx     = in_radius ? gdds_pkg::TblIdxW'(off_sq) : '0;
      sweep_addr  = gdds_pkg::cell_addr(r_pos[7:0], c_pos[7:0]);
      sweep_last  = (dr_ff == gdds_pkg::OffMax) && (dc_ff == gdds_pkg::OffMax);
   end

   // Memory ports: clearing pass, cell writes, center read and window reads.
   always_comb begin
      ram_wr.en   = 1'b0;
      ram_wr.addr = gdds_pkg::cell_addr(8'(req_word.row), 8'(req_word.col));
      ram_wr.data = '{open_mark: req_word.open_cell,
                      homes: gdds_pkg::HomeW'(homes_sat)};
      if (state_ff == StClear) begin
         ram_wr.en   = 1'b1;
         ram_wr.addr = clr_addr_ff;
         ram_wr.data = '{open_mark: 1'b1, homes: '0};
      end else if (accept && (req_word.mode == gdds_pkg::ModeWrite) && req_on_grid) begin
         ram_wr.en = 1'b1;
      end
      ram_rd_addr = (state_ff == StSweep) ? sweep_addr :
                    gdds_pkg::cell_addr(8'(req_word.row), 8'(req_word.col));
   end

   // Sequencer and multiply-accumulate pipeline.
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      q_row_in     = q_row_ff;
      q_col_in     = q_col_ff;
      dr_in        = dr_ff;
      dc_in        = dc_ff;
      drain_in     = drain_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = '{density: '0, computed: 1'b0};
      tap_in       = (state_ff == StSweep) && tap_on_grid && in_radius;
      weight_in    = gdds_pkg::WeightTable[tbl_idx];
      prod_in      = tap_ff ? (gdds_pkg::ProdW'(ram_rd_data.homes) * gdds_pkg::ProdW'(weight_ff))
                            : '0;
      acc_in       = acc_ff + gdds_pkg::AccW'(prod_ff);

      unique case (state_ff)
         StClear: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == gdds_pkg::AddrW'(gdds_pkg::Cells - 1)) begin
               state_in = StIdle;
            end
         end
         StIdle: begin
            if (accept && (req_word.mode == gdds_pkg::ModeQuery)) begin
               q_row_in = req_word.row;
               q_col_in = req_word.col;
               if (req_on_grid) begin
                  state_in = StCheck;
               end else begin
                  // Off-grid query answers at once as not computed.
                  rsp_valid_in = 1'b1;
               end
            end
         end
         StCheck: begin
            // Center cell data is back; a service cell ends the query.
            acc_in = '0;
            dr_in  = gdds_pkg::OffMin;
            dc_in  = gdds_pkg::OffMin;
            if (ram_rd_data.open_mark) begin
               state_in = StSweep;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         StSweep: begin
            if (dc_ff == gdds_pkg::OffMax) begin
               dc_in = gdds_pkg::OffMin;
               dr_in = dr_ff + 1'b1;
            end else begin
               dc_in = dc_ff + 1'b1;
            end
            if (sweep_last) begin
               drain_in = 1'b0;
               state_in = StDrain;
            end
         end
         StDrain: begin
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            rsp_valid_in         = 1'b1;
            rsp_word_in.computed = 1'b1;
            rsp_word_in.density  = (acc_ff > gdds_pkg::DensityMax) ?
                                   gdds_pkg::DensityMax[gdds_pkg::DensityW-1:0] :
                                   acc_ff[gdds_pkg::DensityW-1:0];
            state_in             = StIdle;
         end
         default: begin
            state_in = StClear;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StClear;
         clr_addr_ff  <= '0;
         tap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and datapath registers.
   always_ff @(posedge clock) begin
      q_row_ff    <= q_row_in;
      q_col_ff    <= q_col_in;
      dr_ff       <= dr_in;
      dc_ff       <= dc_in;
      drain_ff    <= drain_in;
      weight_ff   <= weight_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

>>> hdl/gdds_checker.sv
module gdds_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input gdds_pkg::req_type req_word,
   input logic              rsp_strobe,
   input gdds_pkg::rsp_type rsp_word
);

   // Reset always starts the clearing pass.
   assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   // A cell that is not computed reports zero density.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.computed) |-> (rsp_word.density == '0))
      else $error("density set on a word that was not computed");

   // A cell write needs no result and keeps the block free.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.mode == gdds_pkg::ModeWrite)) |=> (!busy && !rsp_strobe))
      else $error("cell write caused busy or a result");

   // A query of an on-grid cell occupies the block while the center cell is read.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.mode == gdds_pkg::ModeQuery) &&
       (32'(req_word.row) < gdds_pkg::GridRows) &&
       (32'(req_word.col) < gdds_pkg::GridCols)) |=> (busy && !rsp_strobe))
      else $error("on-grid query did not raise busy");

endmodule

bind gaussian_disk_density_sum gdds_checker u_gdds_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);
